@@ rtl/core/whsp_pkg.sv @@
// ----------------------------------------------------------------------------
// whsp_pkg
// Shared types and constants for the WAV header stream parser.
// ----------------------------------------------------------------------------
`default_nettype none

package whsp_pkg;

  // Input item action codes
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_EOS  = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_REPORT = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_TAG      = 3'd0;
  localparam logic [2:0] ERR_NOT_PCM  = 3'd1;
  localparam logic [2:0] ERR_CHANNELS = 3'd2;
  localparam logic [2:0] ERR_BITS     = 3'd3;
  localparam logic [2:0] ERR_TRUNC    = 3'd4;
  localparam logic [2:0] ERR_NO_DATA  = 3'd5;

  // Chunk tags, big-endian as they are shifted in
  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam logic [31:0] TAG_LEN       = 32'd4;
  localparam logic [31:0] CHUNK_HDR_LEN = 32'd8;
  localparam logic [31:0] FILE_HDR_LEN  = 32'd12;
  localparam logic [4:0]  FMT_CAPTURE   = 5'd16;

  localparam logic [15:0] PCM_TAG = 16'd1;

  typedef enum logic [3:0] {
    PH_FILEHDR  = 4'd0,
    PH_CHUNKHDR = 4'd1,
    PH_FMT      = 4'd2,
    PH_SKIP     = 4'd3,
    PH_DATA     = 4'd4,
    PH_DONE     = 4'd5,
    PH_HALT     = 4'd6
  } whsp_phase_t;

  typedef struct packed {
    whsp_phase_t phase;
    logic [31:0] bytes_left;
    logic [31:0] tag_shift;
    logic [31:0] size_shift;
    logic [4:0]  fmt_offset;
    logic [15:0] format_tag;
    logic [15:0] channels_seen;
    logic [31:0] rate_seen;
    logic [15:0] bits_seen;
  } whsp_state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  sample_byte;
    logic        last;
    logic [1:0]  channel_count;
    logic [4:0]  sample_bits;
    logic [31:0] rate_hz;
    logic [31:0] frame_count;
    logic [2:0]  error_code;
  } whsp_result_t;

  localparam whsp_state_t STATE_RESET = '{
    phase:         PH_FILEHDR,
    bytes_left:    32'd0,
    tag_shift:     32'd0,
    size_shift:    32'd0,
    fmt_offset:    5'd0,
    format_tag:    16'd0,
    channels_seen: 16'd0,
    rate_seen:     32'd0,
    bits_seen:     16'd0
  };

endpackage

`default_nettype wire

@@ rtl/core/whsp_in_if.sv @@
// ----------------------------------------------------------------------------
// whsp_in_if
// Byte stream channel: valid/ready plus action and file byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface whsp_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] file_byte;

  modport source (output valid, output action, output file_byte, input ready);
  modport sink   (input valid, input action, input file_byte, output ready);
endinterface

`default_nettype wire

@@ rtl/core/whsp_out_if.sv @@
// ----------------------------------------------------------------------------
// whsp_out_if
// Result channel: valid/ready plus sample, report and error fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface whsp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  sample_byte;
  logic        last;
  logic [1:0]  channel_count;
  logic [4:0]  sample_bits;
  logic [31:0] rate_hz;
  logic [31:0] frame_count;
  logic [2:0]  error_code;

  modport source (
    output valid, output kind, output sample_byte, output last,
    output channel_count, output sample_bits, output rate_hz,
    output frame_count, output error_code, input ready
  );
  modport sink (
    input valid, input kind, input sample_byte, input last,
    input channel_count, input sample_bits, input rate_hz,
    input frame_count, input error_code, output ready
  );
endinterface

`default_nettype wire

@@ rtl/core/whsp_parse.sv @@
// ----------------------------------------------------------------------------
// whsp_parse
// Next-state and result logic for one item of the WAV byte stream.
// ----------------------------------------------------------------------------
`default_nettype none

module whsp_parse import whsp_pkg::*; (
  input  whsp_state_t  state,
  input  logic         action,
  input  logic [7:0]   file_byte,
  output whsp_state_t  state_next,
  output logic         res_valid,
  output whsp_result_t res
);

  // Format check against captured fmt fields
  logic       fault;
  logic [2:0] fault_code;

  always_comb begin
    fault      = 1'b1;
    fault_code = ERR_NOT_PCM;
    if (state.format_tag != PCM_TAG) begin
      fault_code = ERR_NOT_PCM;
    end else if (state.channels_seen != 16'd1 && state.channels_seen != 16'd2) begin
      fault_code = ERR_CHANNELS;
    end else if (state.bits_seen != 16'd8 && state.bits_seen != 16'd16) begin
      fault_code = ERR_BITS;
    end else begin
      fault = 1'b0;
    end
  end

  logic [31:0] bl_inc;
  logic [31:0] bl_dec;
  logic [31:0] tag_new;
  logic [31:0] size_new;
  logic [1:0]  frame_shift;
  logic [4:0]  off;

  assign bl_inc  = state.bytes_left + 32'd1;
  assign bl_dec  = state.bytes_left - 32'd1;
  assign tag_new = {state.tag_shift[23:0], file_byte};
  assign off     = state.fmt_offset;

  // bytes per frame is 1, 2 or 4: frame count is a shift of the size
  assign frame_shift = {1'b0, state.channels_seen == 16'd2}
                     + {1'b0, state.bits_seen == 16'd16};

  always_comb begin
    state_next = state;
    res_valid  = 1'b0;
    res        = '0;
    size_new   = state.size_shift;

    if (action == ACT_EOS) begin
      state_next = STATE_RESET;
      unique case (state.phase)
        PH_FILEHDR, PH_DATA: begin
          res_valid      = 1'b1;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_TRUNC;
        end
        PH_FMT, PH_CHUNKHDR, PH_SKIP: begin
          res_valid = 1'b1;
          res.kind  = KIND_ERROR;
          if (state.phase == PH_FMT && off < FMT_CAPTURE) begin
            res.error_code = ERR_TRUNC;
          end else begin
            res.error_code = fault ? fault_code : ERR_NO_DATA;
          end
        end
        default: begin
        end
      endcase
    end else begin
      unique case (state.phase)
        PH_FILEHDR: begin
          state_next.tag_shift  = tag_new;
          state_next.bytes_left = bl_inc;
          if (bl_inc == TAG_LEN && tag_new != TAG_RIFF) begin
            state_next.phase = PH_HALT;
            res_valid        = 1'b1;
            res.kind         = KIND_ERROR;
            res.error_code   = ERR_TAG;
          end else if (bl_inc == FILE_HDR_LEN) begin
            if (tag_new != TAG_WAVE) begin
              state_next.phase = PH_HALT;
              res_valid        = 1'b1;
              res.kind         = KIND_ERROR;
              res.error_code   = ERR_TAG;
            end else begin
              state_next.phase      = PH_CHUNKHDR;
              state_next.bytes_left = '0;
              state_next.tag_shift  = '0;
              state_next.size_shift = '0;
            end
          end
        end

        PH_CHUNKHDR: begin
          if (state.bytes_left < TAG_LEN) begin
            state_next.tag_shift = tag_new;
          end else begin
            size_new              = {file_byte, state.size_shift[31:8]};
            state_next.size_shift = size_new;
          end
          state_next.bytes_left = bl_inc;
          if (bl_inc == CHUNK_HDR_LEN) begin
            state_next.bytes_left = size_new;
            if (state.tag_shift == TAG_FMT) begin
              state_next.format_tag    = '0;
              state_next.channels_seen = '0;
              state_next.rate_seen     = '0;
              state_next.bits_seen     = '0;
              state_next.fmt_offset    = '0;
              if (size_new == '0) begin
                state_next.phase      = PH_CHUNKHDR;
                state_next.tag_shift  = '0;
                state_next.size_shift = '0;
              end else begin
                state_next.phase = PH_FMT;
              end
            end else if (state.tag_shift == TAG_DATA) begin
              res_valid = 1'b1;
              if (fault) begin
                state_next.phase      = PH_HALT;
                state_next.bytes_left = bl_inc;
                res.kind              = KIND_ERROR;
                res.error_code        = fault_code;
              end else begin
                res.kind          = KIND_REPORT;
                res.last          = (size_new == '0);
                res.channel_count = state.channels_seen[1:0];
                res.sample_bits   = state.bits_seen[4:0];
                res.rate_hz       = state.rate_seen;
                res.frame_count   = size_new >> frame_shift;
                state_next.phase  = (size_new == '0) ? PH_DONE : PH_DATA;
              end
            end else begin
              if (size_new == '0) begin
                state_next.phase      = PH_CHUNKHDR;
                state_next.tag_shift  = '0;
                state_next.size_shift = '0;
              end else begin
                state_next.phase = PH_SKIP;
              end
            end
          end
        end

        PH_FMT: begin
          if (off < FMT_CAPTURE) begin
            state_next.fmt_offset = off + 5'd1;
            if (off < 5'd2) begin
              state_next.format_tag[{off[0], 3'b000} +: 8] =
                state.format_tag[{off[0], 3'b000} +: 8] | file_byte;
            end else if (off < 5'd4) begin
              state_next.channels_seen[{off[0], 3'b000} +: 8] =
                state.channels_seen[{off[0], 3'b000} +: 8] | file_byte;
            end else if (off < 5'd8) begin
              state_next.rate_seen[{off[1:0], 3'b000} +: 8] =
                state.rate_seen[{off[1:0], 3'b000} +: 8] | file_byte;
            end else if (off >= 5'd14) begin
              state_next.bits_seen[{off[0], 3'b000} +: 8] =
                state.bits_seen[{off[0], 3'b000} +: 8] | file_byte;
            end
          end
          state_next.bytes_left = bl_dec;
          if (bl_dec == '0) begin
            state_next.phase      = PH_CHUNKHDR;
            state_next.tag_shift  = '0;
            state_next.size_shift = '0;
          end
        end

        PH_SKIP: begin
          state_next.bytes_left = bl_dec;
          if (bl_dec == '0) begin
            state_next.phase      = PH_CHUNKHDR;
            state_next.tag_shift  = '0;
            state_next.size_shift = '0;
          end
        end

        PH_DATA: begin
          state_next.bytes_left = bl_dec;
          res_valid       = 1'b1;
          res.kind        = KIND_SAMPLE;
          res.sample_byte = (state.bits_seen == 16'd8) ? (file_byte ^ 8'h80) : file_byte;
          res.last        = (bl_dec == '0);
          if (bl_dec == '0) begin
            state_next.phase = PH_DONE;
          end
        end

        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/whsp_out_buf.sv @@
// ----------------------------------------------------------------------------
// whsp_out_buf
// Two-entry result queue; lets the parser run while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module whsp_out_buf import whsp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  whsp_result_t push_data,
  output logic         full,
  output logic         out_valid,
  input  logic         out_ready,
  output whsp_result_t out_data
);

  whsp_result_t entry [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         pop;

  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign pop       = out_valid && out_ready;
  assign out_data  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/wav_header_stream_parser.sv @@
// ----------------------------------------------------------------------------
// wav_header_stream_parser
// RIFF/WAVE PCM header parser: walks chunks byte by byte, reports the format
// at the data chunk and forwards payload bytes (8-bit samples made signed).
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake      item
//   -------  ---  -------------  -----------------------------------------
//   stream   in   valid/ready    action (byte or end of stream), file_byte
//   result   out  valid/ready    kind, sample/report/error fields
//
// One item per cycle while the result queue has room. An accepted item is
// held in the input register, where the parser's state and its result are
// computed; the result lands in a two-entry queue and is offered from there.
// Reset (rst, synchronous) clears the parser to "expecting RIFF header" and
// empties the queue. A stalled result side fills the queue, then holds the
// input register, and only then drops stream.ready.
// ----------------------------------------------------------------------------
`default_nettype none

module wav_header_stream_parser import whsp_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  whsp_in_if.sink        stream,
  whsp_out_if.source     result
);

  // Input register
  logic       in_v;
  logic       in_action;
  logic [7:0] in_byte;

  // Parser state
  whsp_state_t  state;
  whsp_state_t  state_next;
  logic         res_valid;
  whsp_result_t res;

  // Result queue
  logic         buf_full;
  logic         fire;
  logic         push;
  whsp_result_t out_data;

  // The held item is processed as soon as the queue has a free slot,
  // whether or not it makes a result.
  assign fire         = in_v && !buf_full;
  assign push         = fire && res_valid;
  assign stream.ready = !in_v || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (stream.valid && stream.ready) begin
      in_v <= 1'b1;
    end else if (fire) begin
      in_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.valid && stream.ready) begin
      in_action <= stream.action;
      in_byte   <= stream.file_byte;
    end
  end

  // Parser state only advances when an item is consumed
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (fire) begin
      state <= state_next;
    end
  end

  whsp_parse u_parse (
    .state      (state),
    .action     (in_action),
    .file_byte  (in_byte),
    .state_next (state_next),
    .res_valid  (res_valid),
    .res        (res)
  );

  whsp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (res),
    .full      (buf_full),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (out_data)
  );

  assign result.kind          = out_data.kind;
  assign result.sample_byte   = out_data.sample_byte;
  assign result.last          = out_data.last;
  assign result.channel_count = out_data.channel_count;
  assign result.sample_bits   = out_data.sample_bits;
  assign result.rate_hz       = out_data.rate_hz;
  assign result.frame_count   = out_data.frame_count;
  assign result.error_code    = out_data.error_code;

  // Payload bytes only come out of the data phase
  a_sample_from_data: assert property (@(posedge clk) disable iff (rst)
    (push && res.kind == KIND_SAMPLE) |-> (state.phase == PH_DATA))
    else $error("sample result outside data phase");

  // A format report only carries a validated sample width
  a_report_bits: assert property (@(posedge clk) disable iff (rst)
    (push && res.kind == KIND_REPORT) |-> (res.sample_bits == 5'd8 || res.sample_bits == 5'd16))
    else $error("format report with bad sample width");

  // End of stream rearms the parser
  a_eos_rearm: assert property (@(posedge clk) disable iff (rst)
    (fire && in_action == ACT_EOS) |=> (state.phase == PH_FILEHDR && state.bytes_left == '0))
    else $error("end of stream did not rearm parser");

  // The queue never takes a result when full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    buf_full |=> (result.valid && $past(result.ready) ? 1'b1 : buf_full))
    else $error("result queue overflow");

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the WAV header stream parser. A short table of
// hand-picked items comes first. Generated WAV files follow: mostly
// well-formed, with random formats, extra and short chunks, bad tags, cut-off
// files and stray bytes. Each accepted item runs through a cycle-free parser
// model kept here, and every result is compared field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
  import whsp_pkg::*;

  localparam int          RANDOM_ITEMS    = 500;
  localparam int          LONG_PAYLOAD    = 40;    // payload size of the back-pressure file
  localparam int          LONG_HOLD       = 400;   // receiver hold-off, in cycles
  localparam int          WATCHDOG_LIMIT  = 2000;  // cycles with no handshake at all
  localparam int          TAIL_CYCLES     = 8;     // item register plus result queue, with margin
  localparam int          MAX_REPORTS     = 40;
  localparam logic [31:0] TAG_LIST        = 32'h4C49_5354;

  // One row of the directed table. When typed is set, the row carries its own
  // expectation (yields / code, always an error or nothing); otherwise the
  // parser model decides.
  typedef struct packed {
    logic       act;
    logic [7:0] val;
    logic       typed;
    logic       yields;
    logic [2:0] code;
  } dir_row_t;

  localparam int DIR_ROWS_N = 23;
  localparam dir_row_t DIR_ROWS [DIR_ROWS_N] = '{
    '{ACT_EOS,  8'h00, 1'b1, 1'b1, ERR_TRUNC},    // end of stream straight after reset
    '{ACT_BYTE, 8'h52, 1'b1, 1'b0, ERR_TAG},      // "RIF" then X: bad RIFF tag
    '{ACT_BYTE, 8'h49, 1'b1, 1'b0, ERR_TAG},
    '{ACT_BYTE, 8'h46, 1'b1, 1'b0, ERR_TAG},
    '{ACT_BYTE, 8'h58, 1'b1, 1'b1, ERR_TAG},
    '{ACT_BYTE, 8'hFF, 1'b1, 1'b0, ERR_TAG},      // ignored after the error
    '{ACT_EOS,  8'h00, 1'b1, 1'b0, ERR_TAG},      // error already out: silent rearm
    '{ACT_BYTE, 8'h52, 1'b0, 1'b0, ERR_TAG},      // good header, RIFF size 0xFF00FF00
    '{ACT_BYTE, 8'h49, 1'b0, 1'b0, ERR_TAG},
    '{ACT_BYTE, 8'h46, 1'b0, 1'b0, ERR_TAG},
    '{ACT_BYTE, 8'h46, 1'b0, 1'b0, ERR_TAG},
    '{ACT_BYTE, 8'h00, 1'b0, 1'b0, ERR_TAG},
    '{ACT_BYTE, 8'hFF, 1'b0, 1'b0, ERR_TAG},
    '{ACT_BYTE, 8'h00, 1'b0, 1'b0, ERR_TAG},
    '{ACT_BYTE, 8'hFF, 1'b0, 1'b0, ERR_TAG},
    '{ACT_BYTE, 8'h57, 1'b0, 1'b0, ERR_TAG},
    '{ACT_BYTE, 8'h41, 1'b0, 1'b0, ERR_TAG},
    '{ACT_BYTE, 8'h56, 1'b0, 1'b0, ERR_TAG},
    '{ACT_BYTE, 8'h45, 1'b1, 1'b0, ERR_TAG},
    '{ACT_EOS,  8'h00, 1'b1, 1'b1, ERR_NOT_PCM},  // no fmt chunk: tag reads zero
    '{ACT_BYTE, 8'h52, 1'b0, 1'b0, ERR_TAG},
    '{ACT_BYTE, 8'h49, 1'b0, 1'b0, ERR_TAG},
    '{ACT_EOS,  8'h00, 1'b1, 1'b1, ERR_TRUNC}     // cut inside the file header
  };

  typedef enum logic [1:0] {RX_OPEN, RX_HALF, RX_SPARSE} rx_mode_t;

  logic clk;
  logic rst;

  whsp_in_if  stream_if ();
  whsp_out_if result_if ();

  wav_header_stream_parser u_top (
    .clk    (clk),
    .rst    (rst),
    .stream (stream_if),
    .result (result_if)
  );

  // Sideband that travels with each driven item: the directed table's own
  // expectation, if the row has one.
  logic       row_typed;
  logic       row_yields;
  logic [2:0] row_code;

  whsp_state_t  pstate = STATE_RESET;  // parser model state
  whsp_result_t due_results [$];       // results owed by the block, oldest first
  logic [7:0]   file_q [$];            // bytes of the file being sent

  int       mismatch_count = 0;
  int       results_seen   = 0;
  int       live_items     = 0;  // accepted items the parser actually acts on
  int       burst_left     = 0;
  bit       hold_go        = 1'b0;
  logic     long_hold      = 1'b0;
  rx_mode_t rx_mode        = RX_OPEN;
  int       rx_left        = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Parser model
  // --------------------------------------------------------------------------
  function automatic whsp_result_t error_result(input logic [2:0] code);
    whsp_result_t r;
    r            = '0;
    r.kind       = KIND_ERROR;
    r.error_code = code;
    return r;
  endfunction

  // Format check done at the data chunk and on most ends of stream.
  function automatic bit format_bad(output logic [2:0] code);
    code = ERR_NOT_PCM;
    if (pstate.format_tag != PCM_TAG) return 1'b1;
    code = ERR_CHANNELS;
    if (pstate.channels_seen < 16'd1 || pstate.channels_seen > 16'd2) return 1'b1;
    code = ERR_BITS;
    if (pstate.bits_seen != 16'd8 && pstate.bits_seen != 16'd16) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void to_chunk_header();
    pstate.phase      = PH_CHUNKHDR;
    pstate.bytes_left = '0;
    pstate.tag_shift  = '0;
    pstate.size_shift = '0;
  endfunction

  // Advances the model by one item; returns 1 when the item causes a result.
  function automatic bit parse_item(input logic act, input logic [7:0] b,
                                    output whsp_result_t r);
    logic [2:0]  code;
    logic [31:0] sz;
    logic [31:0] per_frame;
    bit          hit;
    r   = '0;
    hit = 1'b0;

    if (act == ACT_EOS) begin
      case (pstate.phase)
        PH_FILEHDR, PH_DATA: begin
          r   = error_result(ERR_TRUNC);
          hit = 1'b1;
        end
        PH_FMT, PH_CHUNKHDR, PH_SKIP: begin
          // inside the captured part of fmt it is a truncation; past it, or
          // between chunks, the format verdict decides
          if (pstate.phase == PH_FMT && pstate.fmt_offset < FMT_CAPTURE)
            r = error_result(ERR_TRUNC);
          else if (format_bad(code))
            r = error_result(code);
          else
            r = error_result(ERR_NO_DATA);
          hit = 1'b1;
        end
        default: ;
      endcase
      pstate = STATE_RESET;
      return hit;
    end

    case (pstate.phase)
      PH_FILEHDR: begin
        pstate.tag_shift  = {pstate.tag_shift[23:0], b};
        pstate.bytes_left = pstate.bytes_left + 1;
        if ((pstate.bytes_left == TAG_LEN && pstate.tag_shift != TAG_RIFF) ||
            (pstate.bytes_left == FILE_HDR_LEN && pstate.tag_shift != TAG_WAVE)) begin
          pstate.phase = PH_HALT;
          r            = error_result(ERR_TAG);
          hit          = 1'b1;
        end else if (pstate.bytes_left == FILE_HDR_LEN) begin
          to_chunk_header();
        end
      end
      PH_CHUNKHDR: begin
        // tag is big-endian, size little-endian
        if (pstate.bytes_left < TAG_LEN) pstate.tag_shift = {pstate.tag_shift[23:0], b};
        else pstate.size_shift = {b, pstate.size_shift[31:8]};
        pstate.bytes_left = pstate.bytes_left + 1;
        if (pstate.bytes_left == CHUNK_HDR_LEN) begin
          sz = pstate.size_shift;
          if (pstate.tag_shift == TAG_FMT) begin
            pstate.format_tag    = '0;
            pstate.channels_seen = '0;
            pstate.rate_seen     = '0;
            pstate.bits_seen     = '0;
            pstate.fmt_offset    = '0;
            if (sz == 0) begin
              to_chunk_header();
            end else begin
              pstate.phase      = PH_FMT;
              pstate.bytes_left = sz;
            end
          end else if (pstate.tag_shift == TAG_DATA) begin
            if (format_bad(code)) begin
              pstate.phase = PH_HALT;
              r            = error_result(code);
            end else begin
              per_frame       = 32'(pstate.channels_seen) * 32'(pstate.bits_seen / 16'd8);
              r.kind          = KIND_REPORT;
              r.last          = (sz == 0);
              r.channel_count = pstate.channels_seen[1:0];
              r.sample_bits   = pstate.bits_seen[4:0];
              r.rate_hz       = pstate.rate_seen;
              r.frame_count   = sz / per_frame;
              pstate.bytes_left = sz;
              if (sz == 0) pstate.phase = PH_DONE;
              else pstate.phase = PH_DATA;
            end
            hit = 1'b1;
          end else if (sz == 0) begin
            to_chunk_header();
          end else begin
            pstate.phase      = PH_SKIP;
            pstate.bytes_left = sz;
          end
        end
      end
      PH_FMT: begin
        // capture window: tag, channels, rate, bits; byte rate and align skipped
        if (pstate.fmt_offset < FMT_CAPTURE) begin
          if (pstate.fmt_offset < 5'd2)
            pstate.format_tag[8*pstate.fmt_offset[0] +: 8] = b;
          else if (pstate.fmt_offset < 5'd4)
            pstate.channels_seen[8*pstate.fmt_offset[0] +: 8] = b;
          else if (pstate.fmt_offset < 5'd8)
            pstate.rate_seen[8*pstate.fmt_offset[1:0] +: 8] = b;
          else if (pstate.fmt_offset >= 5'd14)
            pstate.bits_seen[8*pstate.fmt_offset[0] +: 8] = b;
          pstate.fmt_offset = pstate.fmt_offset + 1;
        end
        pstate.bytes_left = pstate.bytes_left - 1;
        if (pstate.bytes_left == 0) to_chunk_header();
      end
      PH_SKIP: begin
        pstate.bytes_left = pstate.bytes_left - 1;
        if (pstate.bytes_left == 0) to_chunk_header();
      end
      PH_DATA: begin
        pstate.bytes_left = pstate.bytes_left - 1;
        r.kind        = KIND_SAMPLE;
        r.sample_byte = (pstate.bits_seen == 16'd8) ? (b ^ 8'h80) : b;
        r.last        = (pstate.bytes_left == 0);
        if (pstate.bytes_left == 0) pstate.phase = PH_DONE;
        hit = 1'b1;
      end
      default: ;  // halted or past the payload: bytes ignored
    endcase
    return hit;
  endfunction

  // --------------------------------------------------------------------------
  // File generator
  // --------------------------------------------------------------------------
  function automatic void push_be32(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) file_q.push_back(w[8*i +: 8]);
  endfunction

  function automatic void push_le32(input logic [31:0] w);
    for (int i = 0; i < 4; i++) file_q.push_back(w[8*i +: 8]);
  endfunction

  function automatic logic [31:0] flip_one_bit(input logic [31:0] w);
    return w ^ (32'd1 << $urandom_range(0, 31));
  endfunction

  // fmt chunk, mostly sane; may be short (fields read as zero) or carry a tail.
  function automatic void push_fmt_chunk(input bit clean);
    logic [7:0]  body [16];
    logic [15:0] f_tag;
    logic [15:0] f_ch;
    logic [15:0] f_bits;
    logic [31:0] f_rate;
    int          f_size;
    int          roll;

    roll  = $urandom_range(0, 19);
    f_tag = (clean || roll > 1) ? PCM_TAG : ((roll == 0) ? 16'd0 : 16'($urandom));

    roll = $urandom_range(0, 19);
    if (clean || roll > 2) f_ch = 16'($urandom_range(1, 2));
    else if (roll == 0)    f_ch = 16'd0;
    else if (roll == 1)    f_ch = 16'd3;
    else                   f_ch = 16'($urandom);

    roll = $urandom_range(0, 19);
    if (clean || roll > 3) f_bits = $urandom_range(0, 1) ? 16'd16 : 16'd8;
    else if (roll == 0)    f_bits = 16'd0;
    else if (roll == 1)    f_bits = 16'd12;
    else if (roll == 2)    f_bits = 16'd24;
    else                   f_bits = 16'($urandom);

    roll = $urandom_range(0, 7);
    f_rate = (roll == 0) ? 32'd0 : ((roll == 1) ? 32'hFFFF_FFFF : $urandom);

    for (int i = 0; i < 16; i++) body[i] = 8'($urandom);  // byte rate, align
    {body[1], body[0]}                   = f_tag;
    {body[3], body[2]}                   = f_ch;
    {body[7], body[6], body[5], body[4]} = f_rate;
    {body[15], body[14]}                 = f_bits;

    roll = $urandom_range(0, 19);
    if (clean || roll > 5) f_size = 16;
    else if (roll > 2)     f_size = $urandom_range(17, 24);
    else                   f_size = $urandom_range(0, 15);

    push_be32(TAG_FMT);
    push_le32(f_size);
    for (int i = 0; i < f_size; i++) file_q.push_back((i < 16) ? body[i] : 8'($urandom));
  endfunction

  // Builds one file into file_q. A clean file is a plain PCM file with a
  // long payload, used for the back-pressure stretch.
  function automatic void build_file(input bit clean);
    int          pick;
    int          n_pre;
    int          c_size;
    int          n_pay;
    int          roll;
    logic [31:0] d_size;

    file_q.delete();
    pick = clean ? 99 : $urandom_range(0, 99);

    // stray bytes, sometimes behind a proper RIFF tag
    if (pick < 6) begin
      if (pick < 3) push_be32(TAG_RIFF);
      repeat ($urandom_range(1, 12)) file_q.push_back(8'($urandom));
      return;
    end

    push_be32((pick == 6) ? flip_one_bit(TAG_RIFF) : TAG_RIFF);
    push_le32($urandom);
    push_be32((pick == 7) ? flip_one_bit(TAG_WAVE) : TAG_WAVE);

    n_pre = clean ? 1 : $urandom_range(0, 3);
    for (int i = 0; i < n_pre; i++) begin
      if (clean || $urandom_range(0, 9) < 6) begin
        push_fmt_chunk(clean);
      end else begin
        push_be32($urandom_range(0, 1) ? TAG_LIST : $urandom);
        c_size = $urandom_range(0, 6);
        push_le32(c_size);
        repeat (c_size) file_q.push_back(8'($urandom));
      end
    end

    if (clean || $urandom_range(0, 9) != 0) begin
      roll = $urandom_range(0, 9);
      if (clean)          d_size = LONG_PAYLOAD;
      else if (roll == 0) d_size = 0;
      else if (roll == 1) d_size = $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom;
      else                d_size = $urandom_range(1, 16);
      push_be32(TAG_DATA);
      push_le32(d_size);
      // huge sizes are always cut short: stream ends inside the payload
      n_pay = (clean || d_size <= 16) ? int'(d_size) : $urandom_range(0, 6);
      repeat (n_pay) file_q.push_back(8'($urandom));
      if (!clean && n_pay == d_size && $urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 4)) file_q.push_back(8'($urandom));
    end

    // truncated file: stream ends anywhere
    if (!clean && file_q.size() > 0 && $urandom_range(0, 7) == 0) begin
      n_pay = $urandom_range(0, file_q.size() - 1);
      while (file_q.size() > n_pay) void'(file_q.pop_back());
    end
  endfunction

  // --------------------------------------------------------------------------
  // Sender: bursts of random length with random gaps in between
  // --------------------------------------------------------------------------
  task automatic send_item(input logic act, input logic [7:0] val, input logic typed,
                           input logic yields, input logic [2:0] code);
    if (burst_left == 0) begin
      stream_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
    end
    stream_if.valid     <= 1'b1;
    stream_if.action    <= act;
    stream_if.file_byte <= val;
    row_typed           <= typed;
    row_yields          <= yields;
    row_code            <= code;
    @(posedge clk);
    while (!stream_if.ready) @(posedge clk);
    burst_left--;
  endtask

  task automatic send_file();
    foreach (file_q[i]) send_item(ACT_BYTE, file_q[i], 1'b0, 1'b0, ERR_TAG);
    send_item(ACT_EOS, 8'($urandom), 1'b0, 1'b0, ERR_TAG);
    // a second end of stream hits a freshly rearmed parser
    if ($urandom_range(0, 19) == 0) send_item(ACT_EOS, 8'h00, 1'b0, 1'b0, ERR_TAG);
  endtask

  // Sender stays idle until the block has returned everything owed.
  task automatic wait_drained();
    stream_if.valid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stall pattern in modes, plus one long hold-off
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 2));
      rx_left <= $urandom_range(20, 150);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN: result_if.ready <= !long_hold;
      RX_HALF: result_if.ready <= !long_hold && ($urandom_range(0, 1) == 1);
      default: result_if.ready <= !long_hold && ($urandom_range(0, 3) == 0);
    endcase
  end

  // Holds the result side off while a long payload streams in, so the result
  // queue fills and the block drops stream.ready.
  initial begin
    wait (hold_go);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    long_hold <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("MISMATCH result %0d %0s: got %0h, expected %0h", results_seen, what, got, want);
  endtask

  task automatic check_result();
    whsp_result_t due;
    results_seen++;
    if (due_results.size() == 0) begin
      report_mismatch("unexpected, kind", result_if.kind, '0);
      return;
    end
    due = due_results.pop_front();
    if (result_if.kind !== due.kind)
      report_mismatch("kind", result_if.kind, due.kind);
    if (result_if.sample_byte !== due.sample_byte)
      report_mismatch("sample_byte", result_if.sample_byte, due.sample_byte);
    if (result_if.last !== due.last)
      report_mismatch("last", result_if.last, due.last);
    if (result_if.channel_count !== due.channel_count)
      report_mismatch("channel_count", result_if.channel_count, due.channel_count);
    if (result_if.sample_bits !== due.sample_bits)
      report_mismatch("sample_bits", result_if.sample_bits, due.sample_bits);
    if (result_if.rate_hz !== due.rate_hz)
      report_mismatch("rate_hz", result_if.rate_hz, due.rate_hz);
    if (result_if.frame_count !== due.frame_count)
      report_mismatch("frame_count", result_if.frame_count, due.frame_count);
    if (result_if.error_code !== due.error_code)
      report_mismatch("error_code", result_if.error_code, due.error_code);
  endtask

  // Both channels are observed at the clock edge. An accepted item can't
  // produce its result at the same edge, so pop/push order doesn't matter.
  always @(posedge clk) begin : observe
    whsp_result_t predicted;
    bit           yields;
    if (!rst) begin
      if (result_if.valid && result_if.ready) check_result();
      if (stream_if.valid && stream_if.ready) begin
        if (stream_if.action == ACT_EOS ||
            (pstate.phase != PH_HALT && pstate.phase != PH_DONE))
          live_items++;
        yields = parse_item(stream_if.action, stream_if.file_byte, predicted);
        if (row_typed) begin
          if (row_yields) due_results.push_back(error_result(row_code));
        end else if (yields) begin
          due_results.push_back(predicted);
        end
      end
    end
  end

  // Ends the run if neither side moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((stream_if.valid && stream_if.ready) || (result_if.valid && result_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no handshake for %0d cycles, %0d results due",
             WATCHDOG_LIMIT, due_results.size());
    $display("end of test: mismatches");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst                 = 1'b1;
    stream_if.valid     = 1'b0;
    stream_if.action    = ACT_BYTE;
    stream_if.file_byte = 8'h00;
    result_if.ready     = 1'b0;
    row_typed           = 1'b0;
    row_yields          = 1'b0;
    row_code            = ERR_TAG;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: tag errors, early ends of stream, header extremes
    for (int i = 0; i < DIR_ROWS_N; i++)
      send_item(DIR_ROWS[i].act, DIR_ROWS[i].val, DIR_ROWS[i].typed,
                DIR_ROWS[i].yields, DIR_ROWS[i].code);
    wait_drained();

    // back-pressure: long payload while the receiver holds off
    hold_go = 1'b1;
    build_file(1'b1);
    send_file();

    // random files; now and then the sender waits for the block to drain
    while (live_items < RANDOM_ITEMS) begin
      build_file(1'b0);
      send_file();
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && due_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/whsp_pkg.sv
rtl/core/whsp_in_if.sv
rtl/core/whsp_out_if.sv
rtl/core/whsp_parse.sv
rtl/core/whsp_out_buf.sv
rtl/core/wav_header_stream_parser.sv
verif/tb_top.sv
